// File: rtl/srmp_pkg.sv
`default_nettype none

package srmp_pkg;

  // Field and datapath widths.
  localparam int PERIOD_W   = 32;
  localparam int SPEED_W    = 16;
  localparam int COUNT_W    = 31;
  localparam int MOVED_W    = 32;
  localparam int RAMP_W     = 33;
  localparam int OPCODE_W   = 4;
  localparam int GUIDE_W    = 4;
  localparam int DIVIDEND_W = 36;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Limits and scale factors.
  localparam logic [SPEED_W-1:0]  SPEED_MAX   = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;
  localparam logic [4:0]          GUIDE_SCALE = 5'd10;

  // Register values after reset.
  localparam logic [PERIOD_W-1:0] RST_BASE_HALF_PERIOD = 32'd1000000;
  localparam logic [COUNT_W-1:0]  RST_ACCEL_BUDGET     = 31'd100000;
  localparam logic [COUNT_W-1:0]  RST_DECEL_BUDGET     = 31'd100000;
  localparam logic [SPEED_W-1:0]  RST_MAX_SPEED        = 16'd64;
  localparam logic [GUIDE_W-1:0]  RST_GUIDE_RATE       = 4'd5;
  localparam logic                RST_REST_DIRECTION   = 1'b0;

  // Command codes of the input channel.
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK        = 4'd0,
    OP_START       = 4'd1,
    OP_STOP        = 4'd2,
    OP_MOVE        = 4'd3,
    OP_DECELERATE  = 4'd4,
    OP_GUIDE_WEST  = 4'd5,
    OP_GUIDE_EAST  = 4'd6,
    OP_GUIDE_STOP  = 4'd7,
    OP_RESTORE_DIR = 4'd8
  } op_t;

  // Motion phase as reported on the result channel.
  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_FULL  = 2'd2,
    PH_DECEL = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_HALF_PERIOD = 3'd0,
    CFG_ACCEL_BUDGET     = 3'd1,
    CFG_DECEL_BUDGET     = 3'd2,
    CFG_MAX_SPEED        = 3'd3,
    CFG_GUIDE_RATE       = 3'd4,
    CFG_REST_DIRECTION   = 3'd5
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_RAMP,
    SQ_DIV,
    SQ_WRITE
  } seq_state_t;

  // Request to the serial divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SPEED_W-1:0]    divisor;
  } div_req_t;

  // Status and result of the serial divider.
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/srmp_in_if.sv
`default_nettype none

interface srmp_in_if;
  logic                           valid;
  logic                           ready;
  logic [srmp_pkg::OPCODE_W-1:0]  opcode;
  logic                           move_direction;
  logic [srmp_pkg::COUNT_W-1:0]   move_steps;
  logic [srmp_pkg::COUNT_W-1:0]   decel_point;

  modport source (
    output valid, opcode, move_direction, move_steps, decel_point,
    input  ready
  );

  modport sink (
    input  valid, opcode, move_direction, move_steps, decel_point,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/srmp_out_if.sv
`default_nettype none

interface srmp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           step_level;
  logic                           direction_level;
  logic [srmp_pkg::PERIOD_W-1:0]  timer_period;
  logic                           period_reloaded;
  logic [1:0]                     motor_phase;
  logic [srmp_pkg::SPEED_W-1:0]   speed_multiple;
  logic [srmp_pkg::MOVED_W-1:0]   steps_moved;
  logic [srmp_pkg::COUNT_W-1:0]   steps_left;
  logic                           running;
  logic                           move_done;

  modport source (
    output valid, step_level, direction_level, timer_period, period_reloaded,
           motor_phase, speed_multiple, steps_moved, steps_left, running, move_done,
    input  ready
  );

  modport sink (
    input  valid, step_level, direction_level, timer_period, period_reloaded,
           motor_phase, speed_multiple, steps_moved, steps_left, running, move_done,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/srmp_div.sv
`default_nettype none

// Restoring serial divider: one quotient bit per cycle, MSB first.
module srmp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srmp_pkg::div_req_t req,
  output srmp_pkg::div_rsp_t      rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [srmp_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [srmp_pkg::DIVIDEND_W-1:0]   quo_r, quo_nxt;
  logic [srmp_pkg::SPEED_W-1:0]      rem_r, rem_nxt;
  logic [srmp_pkg::SPEED_W-1:0]      dvs_r, dvs_nxt;
  logic [srmp_pkg::SPEED_W:0]        trial;
  logic [srmp_pkg::SPEED_W:0]        trial_diff;
  logic                              trial_ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial      = {rem_r, quo_r[srmp_pkg::DIVIDEND_W-1]};
  assign trial_diff = trial - {1'b0, dvs_r};
  assign trial_ge   = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      // A zero divisor is taken as one.
      busy_nxt = 1'b1;
      cnt_nxt  = srmp_pkg::DIV_CNT_W'(srmp_pkg::DIV_STEPS - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = (req.divisor == '0) ? srmp_pkg::SPEED_W'(1) : req.divisor;
    end else if (busy_r) begin
      rem_nxt = trial_ge ? trial_diff[srmp_pkg::SPEED_W-1:0] : trial[srmp_pkg::SPEED_W-1:0];
      quo_nxt = {quo_r[srmp_pkg::DIVIDEND_W-2:0], trial_ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control flags are reset; the datapath registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // The partial remainder always stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dvs_r))
    else $error("divider remainder reached the divisor");

  // A finished division is never still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reported done while busy");

endmodule

`default_nettype wire

// File: rtl/stepper_ramp_controller.sv
// Trapezoidal ramp generator for a stepper-driven tracking axis.
// in_stream carries one command beat: a tick (one step half-period) or a
// start, stop, move, decelerate, guide or restore-direction command.
// out_stream returns exactly one beat per command with the pin levels,
// timer period, motion phase, speed and step counts after that command.
// cfg_we/cfg_index/cfg_wdata write the six configuration registers; writes
// are taken at once and are expected only while no command is in flight.
// Commands that do not touch the period pass the decode and write states; a
// tick with the timer running also passes the ramp state, and a recomputed
// period waits on the 36-step serial divider that all period calculations
// share. The next command is taken in the cycle after its predecessor's
// result has been registered. One command is worked on at a time; a result
// that waits on out_stream lets the next command run, but that command's
// result holds in the sequencer until the output register is free.
// Synchronous reset loads the configuration defaults, stops the timer, sets
// speed one at the base period and clears all counts and the output beat.
`default_nettype none

module stepper_ramp_controller (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  srmp_in_if.sink                                in_stream,
  srmp_out_if.source                             out_stream,
  input  wire logic                              cfg_we,
  input  wire logic [srmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srmp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic [srmp_pkg::PERIOD_W-1:0]   base_r;
  logic [srmp_pkg::COUNT_W-1:0]    accel_r;
  logic [srmp_pkg::COUNT_W-1:0]    decel_r;
  logic [srmp_pkg::SPEED_W-1:0]    max_speed_r;
  logic [srmp_pkg::GUIDE_W-1:0]    guide_r;
  logic                            rest_dir_r;

  // Motion state.
  srmp_pkg::seq_state_t            state_r, state_nxt;
  logic                            step_pin_r, step_pin_nxt;
  logic                            dir_pin_r, dir_pin_nxt;
  srmp_pkg::phase_t                phase_r, phase_nxt;
  logic [srmp_pkg::SPEED_W-1:0]    speed_r, speed_nxt;
  logic [srmp_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [srmp_pkg::RAMP_W-1:0]     ramp_r, ramp_nxt;
  logic [srmp_pkg::MOVED_W-1:0]    moved_r, moved_nxt;
  logic [srmp_pkg::COUNT_W-1:0]    remain_r, remain_nxt;
  logic [srmp_pkg::COUNT_W-1:0]    mark_r, mark_nxt;
  logic                            timer_on_r, timer_on_nxt;
  logic                            reload_r, reload_nxt;
  logic                            done_r, done_nxt;

  // Command held while it is worked on.
  srmp_pkg::op_t                   op_r, op_nxt;
  logic                            mv_dir_r, mv_dir_nxt;
  logic [srmp_pkg::COUNT_W-1:0]    mv_steps_r, mv_steps_nxt;
  logic [srmp_pkg::COUNT_W-1:0]    dpoint_r, dpoint_nxt;

  // Divider operands and launch.
  logic [srmp_pkg::DIVIDEND_W-1:0] dividend_r, dividend_nxt;
  logic [srmp_pkg::SPEED_W-1:0]    divisor_r, divisor_nxt;
  logic                            div_start_r;
  srmp_pkg::div_req_t              div_req;
  srmp_pkg::div_rsp_t              div_rsp;

  // Sequencer decisions from the datapath.
  logic                            exec_to_ramp;
  logic                            need_div;
  logic                            out_load;

  // Output register.
  logic                            out_valid_r;
  logic                            o_step_r, o_dir_r, o_reload_r, o_running_r, o_done_r;
  logic [srmp_pkg::PERIOD_W-1:0]   o_period_r;
  logic [1:0]                      o_phase_r;
  logic [srmp_pkg::SPEED_W-1:0]    o_speed_r;
  logic [srmp_pkg::MOVED_W-1:0]    o_moved_r;
  logic [srmp_pkg::COUNT_W-1:0]    o_remain_r;

  // Shared arithmetic helpers.
  logic [srmp_pkg::SPEED_W-1:0]    speed_inc;
  logic [srmp_pkg::SPEED_W-1:0]    speed_dec;
  logic [srmp_pkg::RAMP_W:0]       ramp_diff;
  logic                            ramp_spent;
  logic [srmp_pkg::DIVIDEND_W-1:0] base_wide;
  logic [srmp_pkg::DIVIDEND_W-1:0] base_x10;
  logic [4:0]                      guide_west_div;
  logic [4:0]                      guide_east_div;
  logic [srmp_pkg::PERIOD_W-1:0]   quot_sat;

  assign speed_inc = (speed_r < srmp_pkg::SPEED_MAX) ? speed_r + 1'b1 : speed_r;
  assign speed_dec = (speed_r != '0) ? speed_r - 1'b1 : speed_r;

  // Ramp budget less one timer period, one bit wider so it cannot wrap.
  assign ramp_diff  = {ramp_r[srmp_pkg::RAMP_W-1], ramp_r}
                    - {2'b00, period_r};
  assign ramp_spent = ramp_diff[srmp_pkg::RAMP_W] || (ramp_diff == '0);

  // Guide periods divide ten times the base period by the guide divisor.
  assign base_wide      = {{(srmp_pkg::DIVIDEND_W - srmp_pkg::PERIOD_W){1'b0}}, base_r};
  assign base_x10       = (base_wide << 3) + (base_wide << 1);
  assign guide_west_div = srmp_pkg::GUIDE_SCALE + {1'b0, guide_r};
  assign guide_east_div = ({1'b0, guide_r} < srmp_pkg::GUIDE_SCALE)
                        ? srmp_pkg::GUIDE_SCALE - {1'b0, guide_r} : 5'd1;

  // A quotient beyond 32 bits saturates.
  assign quot_sat = (div_rsp.quotient[srmp_pkg::DIVIDEND_W-1:srmp_pkg::PERIOD_W] != '0)
                  ? srmp_pkg::PERIOD_MAX
                  : div_rsp.quotient[srmp_pkg::PERIOD_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= srmp_pkg::RST_BASE_HALF_PERIOD;
      accel_r     <= srmp_pkg::RST_ACCEL_BUDGET;
      decel_r     <= srmp_pkg::RST_DECEL_BUDGET;
      max_speed_r <= srmp_pkg::RST_MAX_SPEED;
      guide_r     <= srmp_pkg::RST_GUIDE_RATE;
      rest_dir_r  <= srmp_pkg::RST_REST_DIRECTION;
    end else if (cfg_we) begin
      case (cfg_index)
        srmp_pkg::CFG_BASE_HALF_PERIOD: base_r      <= cfg_wdata;
        srmp_pkg::CFG_ACCEL_BUDGET:     accel_r     <= cfg_wdata[srmp_pkg::COUNT_W-1:0];
        srmp_pkg::CFG_DECEL_BUDGET:     decel_r     <= cfg_wdata[srmp_pkg::COUNT_W-1:0];
        srmp_pkg::CFG_MAX_SPEED:        max_speed_r <= cfg_wdata[srmp_pkg::SPEED_W-1:0];
        srmp_pkg::CFG_GUIDE_RATE:       guide_r     <= cfg_wdata[srmp_pkg::GUIDE_W-1:0];
        srmp_pkg::CFG_REST_DIRECTION:   rest_dir_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Datapath: command decode, step counting, ramp update and period load.
  always_comb begin
    step_pin_nxt = step_pin_r;
    dir_pin_nxt  = dir_pin_r;
    phase_nxt    = phase_r;
    speed_nxt    = speed_r;
    period_nxt   = period_r;
    ramp_nxt     = ramp_r;
    moved_nxt    = moved_r;
    remain_nxt   = remain_r;
    mark_nxt     = mark_r;
    timer_on_nxt = timer_on_r;
    reload_nxt   = reload_r;
    done_nxt     = done_r;
    op_nxt       = op_r;
    mv_dir_nxt   = mv_dir_r;
    mv_steps_nxt = mv_steps_r;
    dpoint_nxt   = dpoint_r;
    dividend_nxt = dividend_r;
    divisor_nxt  = divisor_r;
    exec_to_ramp = 1'b0;
    need_div     = 1'b0;

    case (state_r)
      srmp_pkg::SQ_IDLE: begin
        if (in_stream.valid) begin
          op_nxt       = srmp_pkg::op_t'(in_stream.opcode);
          mv_dir_nxt   = in_stream.move_direction;
          mv_steps_nxt = in_stream.move_steps;
          dpoint_nxt   = in_stream.decel_point;
          reload_nxt   = 1'b0;
          done_nxt     = 1'b0;
        end
      end

      srmp_pkg::SQ_EXEC: begin
        case (op_r)
          srmp_pkg::OP_TICK: begin
            // Toggle the pin; count a step on each rising edge of a move.
            if (timer_on_r) begin
              exec_to_ramp = 1'b1;
              step_pin_nxt = ~step_pin_r;
              if (!step_pin_r && (phase_r != srmp_pkg::PH_STOP)) begin
                moved_nxt = moved_r + 1'b1;
                if (remain_r != '0) begin
                  if ((remain_r <= mark_r) && (phase_r != srmp_pkg::PH_DECEL)) begin
                    phase_nxt = srmp_pkg::PH_DECEL;
                    ramp_nxt  = {2'b00, accel_r} - ramp_r;
                  end
                  remain_nxt = remain_r - 1'b1;
                end
              end
            end
          end
          srmp_pkg::OP_START: begin
            speed_nxt    = srmp_pkg::SPEED_W'(1);
            timer_on_nxt = 1'b1;
          end
          srmp_pkg::OP_STOP: begin
            timer_on_nxt = 1'b0;
          end
          srmp_pkg::OP_MOVE: begin
            if (phase_r == srmp_pkg::PH_STOP) begin
              dir_pin_nxt  = mv_dir_r;
              remain_nxt   = mv_steps_r;
              mark_nxt     = dpoint_r;
              moved_nxt    = '0;
              speed_nxt    = speed_inc;
              reload_nxt   = 1'b1;
              ramp_nxt     = {2'b00, accel_r};
              phase_nxt    = srmp_pkg::PH_ACCEL;
              need_div     = 1'b1;
              dividend_nxt = base_wide;
              divisor_nxt  = speed_inc;
            end
          end
          srmp_pkg::OP_DECELERATE: begin
            if ((phase_r == srmp_pkg::PH_ACCEL) || (phase_r == srmp_pkg::PH_FULL)) begin
              ramp_nxt  = {2'b00, decel_r};
              phase_nxt = srmp_pkg::PH_DECEL;
            end
          end
          srmp_pkg::OP_GUIDE_WEST: begin
            reload_nxt   = 1'b1;
            need_div     = 1'b1;
            dividend_nxt = base_x10;
            divisor_nxt  = {{(srmp_pkg::SPEED_W - 5){1'b0}}, guide_west_div};
          end
          srmp_pkg::OP_GUIDE_EAST: begin
            reload_nxt   = 1'b1;
            need_div     = 1'b1;
            dividend_nxt = base_x10;
            divisor_nxt  = {{(srmp_pkg::SPEED_W - 5){1'b0}}, guide_east_div};
          end
          srmp_pkg::OP_GUIDE_STOP: begin
            period_nxt = base_r;
            reload_nxt = 1'b1;
          end
          srmp_pkg::OP_RESTORE_DIR: begin
            if (phase_r == srmp_pkg::PH_STOP) begin
              dir_pin_nxt = rest_dir_r;
            end
          end
          default: ;
        endcase
      end

      srmp_pkg::SQ_RAMP: begin
        // Spend one period of the budget; a spent budget moves the speed.
        if (phase_r == srmp_pkg::PH_ACCEL) begin
          if (ramp_spent) begin
            ramp_nxt   = {2'b00, accel_r};
            speed_nxt  = speed_inc;
            reload_nxt = 1'b1;
            if (speed_inc >= max_speed_r) begin
              mark_nxt  = (moved_r > {1'b0, srmp_pkg::COUNT_MAX})
                        ? srmp_pkg::COUNT_MAX : moved_r[srmp_pkg::COUNT_W-1:0];
              phase_nxt = srmp_pkg::PH_FULL;
            end
          end else begin
            ramp_nxt = ramp_diff[srmp_pkg::RAMP_W-1:0];
          end
        end else if (phase_r == srmp_pkg::PH_DECEL) begin
          if (ramp_spent) begin
            ramp_nxt   = (remain_r != '0) ? {2'b00, accel_r} : {2'b00, decel_r};
            speed_nxt  = speed_dec;
            reload_nxt = 1'b1;
            if (speed_dec <= srmp_pkg::SPEED_W'(1)) begin
              speed_nxt   = srmp_pkg::SPEED_W'(1);
              phase_nxt   = srmp_pkg::PH_STOP;
              dir_pin_nxt = rest_dir_r;
              done_nxt    = 1'b1;
            end
          end else begin
            ramp_nxt = ramp_diff[srmp_pkg::RAMP_W-1:0];
          end
        end
        if (reload_nxt) begin
          need_div     = 1'b1;
          dividend_nxt = base_wide;
          divisor_nxt  = speed_nxt;
        end
      end

      srmp_pkg::SQ_DIV: begin
        if (div_rsp.done) begin
          period_nxt = quot_sat;
        end
      end

      default: ;
    endcase
  end

  // Result register is free, or is being emptied in this cycle.
  assign out_load = (state_r == srmp_pkg::SQ_WRITE) && (!out_valid_r || out_stream.ready);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srmp_pkg::SQ_IDLE: begin
        if (in_stream.valid) state_nxt = srmp_pkg::SQ_EXEC;
      end
      srmp_pkg::SQ_EXEC: begin
        if (exec_to_ramp)  state_nxt = srmp_pkg::SQ_RAMP;
        else if (need_div) state_nxt = srmp_pkg::SQ_DIV;
        else               state_nxt = srmp_pkg::SQ_WRITE;
      end
      srmp_pkg::SQ_RAMP: begin
        state_nxt = need_div ? srmp_pkg::SQ_DIV : srmp_pkg::SQ_WRITE;
      end
      srmp_pkg::SQ_DIV: begin
        if (div_rsp.done) state_nxt = srmp_pkg::SQ_WRITE;
      end
      srmp_pkg::SQ_WRITE: begin
        if (out_load) state_nxt = srmp_pkg::SQ_IDLE;
      end
      default: state_nxt = srmp_pkg::SQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stream.ready  = (state_r == srmp_pkg::SQ_IDLE);
    div_req.start    = div_start_r;
    div_req.dividend = dividend_r;
    div_req.divisor  = divisor_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srmp_pkg::SQ_IDLE;
      div_start_r <= 1'b0;
      step_pin_r  <= 1'b0;
      dir_pin_r   <= srmp_pkg::RST_REST_DIRECTION;
      phase_r     <= srmp_pkg::PH_STOP;
      speed_r     <= srmp_pkg::SPEED_W'(1);
      period_r    <= srmp_pkg::RST_BASE_HALF_PERIOD;
      ramp_r      <= '0;
      moved_r     <= '0;
      remain_r    <= '0;
      mark_r      <= '0;
      timer_on_r  <= 1'b0;
      reload_r    <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= (state_nxt == srmp_pkg::SQ_DIV) && (state_r != srmp_pkg::SQ_DIV);
      step_pin_r  <= step_pin_nxt;
      dir_pin_r   <= dir_pin_nxt;
      phase_r     <= phase_nxt;
      speed_r     <= speed_nxt;
      period_r    <= period_nxt;
      ramp_r      <= ramp_nxt;
      moved_r     <= moved_nxt;
      remain_r    <= remain_nxt;
      mark_r      <= mark_nxt;
      timer_on_r  <= timer_on_nxt;
      reload_r    <= reload_nxt;
      done_r      <= done_nxt;
    end
  end

  // Command and operand registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mv_dir_r   <= mv_dir_nxt;
    mv_steps_r <= mv_steps_nxt;
    dpoint_r   <= dpoint_nxt;
    dividend_r <= dividend_nxt;
    divisor_r  <= divisor_nxt;
  end

  // Shared divider for every period calculation.
  srmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output beat: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output beat: payload snapshot of the state after the command.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_step_r    <= step_pin_r;
      o_dir_r     <= dir_pin_r;
      o_period_r  <= period_r;
      o_reload_r  <= reload_r;
      o_phase_r   <= phase_r;
      o_speed_r   <= speed_r;
      o_moved_r   <= moved_r;
      o_remain_r  <= remain_r;
      o_running_r <= timer_on_r;
      o_done_r    <= done_r;
    end
  end

  assign out_stream.valid           = out_valid_r;
  assign out_stream.step_level      = o_step_r;
  assign out_stream.direction_level = o_dir_r;
  assign out_stream.timer_period    = o_period_r;
  assign out_stream.period_reloaded = o_reload_r;
  assign out_stream.motor_phase     = o_phase_r;
  assign out_stream.speed_multiple  = o_speed_r;
  assign out_stream.steps_moved     = o_moved_r;
  assign out_stream.steps_left      = o_remain_r;
  assign out_stream.running         = o_running_r;
  assign out_stream.move_done       = o_done_r;

  // While stopped or tracking the axis always runs at speed one.
  a_stop_at_speed_one: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == srmp_pkg::PH_STOP) |-> (speed_r == srmp_pkg::SPEED_W'(1)))
    else $error("stopped phase with speed other than one");

  // The end of a move always comes with a period reload.
  a_done_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> reload_r)
    else $error("move finished without a period reload");

  // The divider only finishes while the sequencer waits on it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == srmp_pkg::SQ_DIV))
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// File: verif/tb_stepper_ramp_controller.sv
`timescale 1ns / 1ps

module tb_stepper_ramp_controller;
  import srmp_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam logic [OPCODE_W-1:0] OP_UNDEFINED = 4'hF;

  // One result beat as the block reports it.
  typedef struct packed {
    logic                step_level;
    logic                direction_level;
    logic [PERIOD_W-1:0] timer_period;
    logic                period_reloaded;
    phase_t              motor_phase;
    logic [SPEED_W-1:0]  speed_multiple;
    logic [MOVED_W-1:0]  steps_moved;
    logic [COUNT_W-1:0]  steps_left;
    logic                running;
    logic                move_done;
  } axis_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  srmp_in_if  in_if ();
  srmp_out_if out_if ();

  stepper_ramp_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the axis state and of the configuration registers.
  logic                ax_step, ax_dir, ax_timer;
  phase_t              ax_phase;
  logic [SPEED_W-1:0]  ax_speed;
  logic [PERIOD_W-1:0] ax_period;
  longint              ax_budget;
  logic [MOVED_W-1:0]  ax_moved;
  logic [COUNT_W-1:0]  ax_left, ax_mark;

  logic [PERIOD_W-1:0] cf_base;
  logic [COUNT_W-1:0]  cf_accel, cf_decel;
  logic [SPEED_W-1:0]  cf_top;
  logic [GUIDE_W-1:0]  cf_guide;
  logic                cf_rest;

  axis_beat_t axis_expected[$];
  int fault_count = 0;
  int report_count = 0;
  int applied_items = 0;
  int hold_request = 0;
  logic eager = 1'b0;

  // Half period at the current speed; a zero speed divides by one.
  function automatic logic [PERIOD_W-1:0] period_at_speed();
    return cf_base / ((ax_speed == '0) ? 32'd1 : {16'd0, ax_speed});
  endfunction

  // Guide period from the wide product of the base period and ten, saturated.
  function automatic logic [PERIOD_W-1:0] guide_period(input logic [4:0] divisor);
    logic [63:0] quot;
    quot = ({32'd0, cf_base} * {59'd0, GUIDE_SCALE}) / {59'd0, divisor};
    return (quot > {32'd0, PERIOD_MAX}) ? PERIOD_MAX : quot[PERIOD_W-1:0];
  endfunction

  // Applies one command to the shadow state and returns the beat it should cause.
  function automatic axis_beat_t predict_axis(input logic [OPCODE_W-1:0] op,
                                              input logic dir,
                                              input logic [COUNT_W-1:0] steps,
                                              input logic [COUNT_W-1:0] dpoint);
    axis_beat_t res;
    logic reload;
    logic done;
    reload = 1'b0;
    done = 1'b0;
    case (op)
      OP_TICK: begin
        if (ax_timer) begin
          // A rising step edge counts a step and may enter the deceleration.
          ax_step = ~ax_step;
          if (ax_step && ax_phase != PH_STOP) begin
            ax_moved = ax_moved + 1'b1;
            if (ax_left != '0) begin
              if (ax_left <= ax_mark && ax_phase != PH_DECEL) begin
                ax_phase = PH_DECEL;
                ax_budget = longint'({33'd0, cf_accel}) - ax_budget;
              end
              ax_left = ax_left - 1'b1;
            end
          end
          // Spend the period against the budget of the current speed level.
          if (ax_phase == PH_ACCEL) begin
            ax_budget = ax_budget - longint'({32'd0, ax_period});
            if (ax_budget <= 0) begin
              ax_budget = longint'({33'd0, cf_accel});
              if (ax_speed != SPEED_MAX) ax_speed = ax_speed + 1'b1;
              reload = 1'b1;
              if (ax_speed >= cf_top) begin
                ax_mark = (ax_moved > {1'b0, COUNT_MAX}) ? COUNT_MAX : ax_moved[COUNT_W-1:0];
                ax_phase = PH_FULL;
              end
            end
          end else if (ax_phase == PH_DECEL) begin
            ax_budget = ax_budget - longint'({32'd0, ax_period});
            if (ax_budget <= 0) begin
              ax_budget = longint'({33'd0, (ax_left != '0) ? cf_accel : cf_decel});
              if (ax_speed != '0) ax_speed = ax_speed - 1'b1;
              reload = 1'b1;
              if (ax_speed <= 16'd1) begin
                ax_speed = 16'd1;
                ax_phase = PH_STOP;
                ax_dir = cf_rest;
                done = 1'b1;
              end
            end
          end
          if (reload) ax_period = period_at_speed();
        end
      end
      OP_START: begin
        ax_speed = 16'd1;
        ax_timer = 1'b1;
      end
      OP_STOP: ax_timer = 1'b0;
      OP_MOVE: begin
        if (ax_phase == PH_STOP) begin
          ax_dir = dir;
          ax_left = steps;
          ax_mark = dpoint;
          ax_moved = '0;
          if (ax_speed != SPEED_MAX) ax_speed = ax_speed + 1'b1;
          ax_period = period_at_speed();
          reload = 1'b1;
          ax_budget = longint'({33'd0, cf_accel});
          ax_phase = PH_ACCEL;
        end
      end
      OP_DECELERATE: begin
        if (ax_phase == PH_ACCEL || ax_phase == PH_FULL) begin
          ax_budget = longint'({33'd0, cf_decel});
          ax_phase = PH_DECEL;
        end
      end
      OP_GUIDE_WEST: begin
        ax_period = guide_period(GUIDE_SCALE + cf_guide);
        reload = 1'b1;
      end
      OP_GUIDE_EAST: begin
        ax_period = guide_period((cf_guide < GUIDE_SCALE) ? GUIDE_SCALE - cf_guide : 5'd1);
        reload = 1'b1;
      end
      OP_GUIDE_STOP: begin
        ax_period = cf_base;
        reload = 1'b1;
      end
      OP_RESTORE_DIR: begin
        if (ax_phase == PH_STOP) ax_dir = cf_rest;
      end
      default: ;
    endcase
    res.step_level = ax_step;
    res.direction_level = ax_dir;
    res.timer_period = ax_period;
    res.period_reloaded = reload;
    res.motor_phase = ax_phase;
    res.speed_multiple = ax_speed;
    res.steps_moved = ax_moved;
    res.steps_left = ax_left;
    res.running = ax_timer;
    res.move_done = done;
    return res;
  endfunction

  // Offers one command beat after a random gap, or none when eager, and records its expected result.
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic dir,
                       input logic [COUNT_W-1:0] steps, input logic [COUNT_W-1:0] dpoint);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.move_direction <= dir;
    in_if.move_steps <= steps;
    in_if.decel_point <= dpoint;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (!((op == OP_TICK && !ax_timer) || op > OP_RESTORE_DIR)) applied_items++;
    axis_expected.push_back(predict_axis(op, dir, steps, dpoint));
  endtask

  // A command whose payload fields are don't-care carries random bits.
  task automatic issue_op(input logic [OPCODE_W-1:0] op);
    issue(op, 1'($urandom_range(0, 1)), 31'($urandom), 31'($urandom));
  endtask

  // Drops valid, waits for every expected result and lets the block settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (axis_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes all six registers back to back while the block is idle.
  task automatic set_config(input logic [PERIOD_W-1:0] base, input logic [COUNT_W-1:0] accel,
                            input logic [COUNT_W-1:0] decel, input logic [SPEED_W-1:0] top,
                            input logic [GUIDE_W-1:0] guide, input logic rest);
    wait_idle();
    cfg_beat(CFG_BASE_HALF_PERIOD, base);
    cfg_beat(CFG_ACCEL_BUDGET, {1'b0, accel});
    cfg_beat(CFG_DECEL_BUDGET, {1'b0, decel});
    cfg_beat(CFG_MAX_SPEED, {16'd0, top});
    cfg_beat(CFG_GUIDE_RATE, {28'd0, guide});
    cfg_beat(CFG_REST_DIRECTION, {31'd0, rest});
    cfg_we <= 1'b0;
    cf_base = base;
    cf_accel = accel;
    cf_decel = decel;
    cf_top = top;
    cf_guide = guide;
    cf_rest = rest;
  endtask

  task automatic run_ticks(input int cap);
    int n;
    n = 0;
    while (ax_phase != PH_STOP && n < cap) begin
      issue_op(OP_TICK);
      n++;
    end
  endtask

  // Forces any move in progress down to tracking.
  task automatic rest_axis();
    if (ax_phase == PH_STOP) return;
    if (!ax_timer) issue_op(OP_START);
    if (ax_phase != PH_DECEL) issue_op(OP_DECELERATE);
    run_ticks(400);
  endtask

  // One well-formed move with random content and the odd interjected command.
  task automatic run_move();
    logic [COUNT_W-1:0] steps;
    logic [COUNT_W-1:0] mark;
    int brake_at;
    int n;
    rest_axis();
    if (!ax_timer || $urandom_range(0, 7) == 0) issue_op(OP_START);
    if ($urandom_range(0, 3) == 0) issue_op(OP_RESTORE_DIR);
    case ($urandom_range(0, 9))
      0: steps = '0;
      1: steps = 31'($urandom);
      default: steps = 31'($urandom_range(1, 60));
    endcase
    mark = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 25));
    issue(OP_MOVE, 1'($urandom_range(0, 1)), steps, mark);
    brake_at = (steps == '0 || steps > 31'd60 || $urandom_range(0, 3) == 0) ?
               $urandom_range(2, 40) : -1;
    n = 0;
    while (ax_phase != PH_STOP && n < 120) begin
      if (n == brake_at) begin
        issue_op(OP_DECELERATE);
      end else if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 5))
          0: issue_op(OP_GUIDE_WEST);
          1: issue_op(OP_GUIDE_EAST);
          2: issue_op(OP_GUIDE_STOP);
          3: issue_op(OP_MOVE);
          4: issue_op(OP_RESTORE_DIR);
          default: begin
            issue_op(OP_STOP);
            issue_op(OP_TICK);
            issue_op(OP_START);
          end
        endcase
      end else begin
        issue_op(OP_TICK);
      end
      n++;
    end
    rest_axis();
  endtask

  // Ignored commands, guides, tracking and the quickest possible moves.
  task automatic test_directed();
    issue_op(OP_TICK);
    issue_op(OP_RESTORE_DIR);
    issue_op(OP_DECELERATE);
    issue(OP_UNDEFINED, 1'b1, '1, '1);
    issue_op(OP_GUIDE_WEST);
    issue_op(OP_GUIDE_EAST);
    issue_op(OP_GUIDE_STOP);
    issue_op(OP_START);
    issue_op(OP_TICK);
    issue_op(OP_TICK);
    // The first counted step lands on the deceleration mark at once.
    issue(OP_MOVE, 1'b1, '1, '1);
    issue(OP_MOVE, 1'b0, '0, '0);
    issue_op(OP_RESTORE_DIR);
    issue_op(OP_TICK);
    issue_op(OP_TICK);
    issue_op(OP_STOP);
    issue_op(OP_TICK);
    issue_op(OP_START);
    issue(OP_MOVE, 1'b0, '0, '0);
    issue_op(OP_DECELERATE);
    issue_op(OP_DECELERATE);
    issue_op(OP_TICK);
    rest_axis();
  endtask

  // Register extremes, guide saturation and a ramp with the speed limit at its maximum.
  task automatic test_config_extremes();
    set_config(PERIOD_MAX, 31'd1, 31'd1, 16'd2, 4'd9, 1'b1);
    issue_op(OP_RESTORE_DIR);
    issue_op(OP_GUIDE_WEST);
    issue_op(OP_GUIDE_EAST);
    issue_op(OP_GUIDE_STOP);
    issue_op(OP_START);
    issue(OP_MOVE, 1'b0, 31'd3, 31'd1);
    run_ticks(40);
    rest_axis();

    set_config(32'd1, COUNT_MAX, COUNT_MAX, SPEED_MAX, 4'd10, 1'b0);
    issue_op(OP_GUIDE_EAST);
    issue_op(OP_GUIDE_WEST);
    issue_op(OP_GUIDE_STOP);
    issue_op(OP_RESTORE_DIR);
    issue_op(OP_TICK);

    set_config(PERIOD_MAX, 31'd1, 31'd1, SPEED_MAX, 4'd15, 1'b1);
    issue_op(OP_GUIDE_EAST);
    issue_op(OP_GUIDE_WEST);
    if (!ax_timer) issue_op(OP_START);
    issue(OP_MOVE, 1'b1, '0, '0);
    repeat (20) issue_op(OP_TICK);
    rest_axis();

    set_config(RST_BASE_HALF_PERIOD, RST_ACCEL_BUDGET, RST_DECEL_BUDGET, RST_MAX_SPEED,
               RST_GUIDE_RATE, RST_REST_DIRECTION);
  endtask

  // The receiver holds off while commands keep coming, then the sender drains.
  task automatic test_backpressure();
    wait_idle();
    eager = 1'b1;
    hold_request <= HOLD_CYCLES;
    if (!ax_timer) issue_op(OP_START);
    issue(OP_MOVE, 1'($urandom_range(0, 1)), '0, '0);
    repeat (12) issue_op(OP_TICK);
    wait_idle();
    repeat (6) issue_op(OP_TICK);
    eager = 1'b0;
    rest_axis();
  endtask

  // Random settings, each with a run of moves mixed with random commands.
  task automatic test_random_moves();
    int round;
    logic [PERIOD_W-1:0] base;
    round = 0;
    applied_items = 0;
    while (applied_items < RANDOM_ITEMS) begin
      base = 32'($urandom_range(100, 200000));
      eager = (round % 4 == 3);
      set_config(base, 31'($urandom_range(1, base)), 31'($urandom_range(1, 2 * base)),
                 16'($urandom_range(2, 8)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
      repeat (5) begin
        if ($urandom_range(0, 9) < 7) begin
          run_move();
        end else begin
          repeat ($urandom_range(1, 6))
            issue(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 31'($urandom),
                  31'($urandom));
        end
      end
      round++;
    end
    eager = 1'b0;
  endtask

  // Result side: random stalls, the long hold-off, and the check of every beat.
  initial begin : beat_checker
    axis_beat_t got;
    axis_beat_t want;
    int stall_left;
    int hold_left;
    logic bad;
    stall_left = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.step_level = out_if.step_level;
        got.direction_level = out_if.direction_level;
        got.timer_period = out_if.timer_period;
        got.period_reloaded = out_if.period_reloaded;
        got.motor_phase = phase_t'(out_if.motor_phase);
        got.speed_multiple = out_if.speed_multiple;
        got.steps_moved = out_if.steps_moved;
        got.steps_left = out_if.steps_left;
        got.running = out_if.running;
        got.move_done = out_if.move_done;
        if (axis_expected.size() == 0) begin
          fault_count++;
          if (report_count < MAX_REPORTS)
            $display("result beat at %0t with no command outstanding", $realtime);
          report_count++;
        end else begin
          want = axis_expected.pop_front();
          bad = (got.step_level !== want.step_level) ||
                (got.direction_level !== want.direction_level) ||
                (got.timer_period !== want.timer_period) ||
                (got.period_reloaded !== want.period_reloaded) ||
                (got.motor_phase !== want.motor_phase) ||
                (got.speed_multiple !== want.speed_multiple) ||
                (got.steps_moved !== want.steps_moved) ||
                (got.steps_left !== want.steps_left) ||
                (got.running !== want.running) ||
                (got.move_done !== want.move_done);
          if (bad) begin
            fault_count++;
            if (report_count < MAX_REPORTS)
              $display({"mismatch at %0t (expected/actual): step %b/%b dir %b/%b",
                        " period %0d/%0d reload %b/%b phase %0d/%0d speed %0d/%0d",
                        " moved %0d/%0d left %0d/%0d run %b/%b done %b/%b"},
                       $realtime, want.step_level, got.step_level,
                       want.direction_level, got.direction_level,
                       want.timer_period, got.timer_period,
                       want.period_reloaded, got.period_reloaded,
                       want.motor_phase, got.motor_phase,
                       want.speed_multiple, got.speed_multiple,
                       want.steps_moved, got.steps_moved,
                       want.steps_left, got.steps_left,
                       want.running, got.running, want.move_done, got.move_done);
            report_count++;
          end
        end
        stall_left = eager ? 0 : $urandom_range(0, 6);
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request <= 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Overall time limit.
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_TICK;
    in_if.move_direction <= 1'b0;
    in_if.move_steps <= '0;
    in_if.decel_point <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BASE_HALF_PERIOD;
    cfg_wdata <= '0;
    // Shadow state and registers as the reset leaves them.
    cf_base = RST_BASE_HALF_PERIOD;
    cf_accel = RST_ACCEL_BUDGET;
    cf_decel = RST_DECEL_BUDGET;
    cf_top = RST_MAX_SPEED;
    cf_guide = RST_GUIDE_RATE;
    cf_rest = RST_REST_DIRECTION;
    ax_step = 1'b0;
    ax_dir = RST_REST_DIRECTION;
    ax_phase = PH_STOP;
    ax_speed = 16'd1;
    ax_period = RST_BASE_HALF_PERIOD;
    ax_budget = 0;
    ax_moved = '0;
    ax_left = '0;
    ax_mark = '0;
    ax_timer = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_moves();
    wait_idle();

    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
